>>> design/assert_macros.svh
// Assertion helpers used by the predecoder design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> design/tbipd_pkg.sv
package tbipd_pkg;

  localparam int WORD_W = 12;
  localparam int CODE_W = 6;
  localparam int MODE_W = 4;
  localparam int OPND_W = 6;
  localparam int LEN_W  = 2;
  localparam int KIND_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [OPND_W-1:0] opnd_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam word_t WORD_MASK = 12'o7777;
  localparam logic [5:0] PTA_MARK = 6'o70;

  // address modes
  localparam mode_t AM_NONE  = 4'd0;
  localparam mode_t AM_IMM   = 4'd1;
  localparam mode_t AM_FWD   = 4'd2;
  localparam mode_t AM_BWD   = 4'd3;
  localparam mode_t AM_DIR   = 4'd4;
  localparam mode_t AM_IND   = 4'd5;
  localparam mode_t AM_SPEC  = 4'd6;
  localparam mode_t AM_CONST = 4'd7;
  localparam mode_t AM_MEM   = 4'd8;

  // step kinds
  localparam kind_t SK_PLAIN = 2'd0;
  localparam kind_t SK_COND  = 2'd1;
  localparam kind_t SK_OVER  = 2'd2;
  localparam kind_t SK_OUT   = 2'd3;

  localparam len_t LEN_ONE = 2'd1;
  localparam len_t LEN_TWO = 2'd2;

  // mnemonic codes
  localparam code_t MN_ERR   = 6'd0;
  localparam code_t MN_SHA   = 6'd1;
  localparam code_t MN_LP    = 6'd2;
  localparam code_t MN_SC    = 6'd12;
  localparam code_t MN_ZJ    = 6'd13;
  localparam code_t MN_JPI   = 6'd17;
  localparam code_t MN_JFI   = 6'd18;
  localparam code_t MN_INP   = 6'd19;
  localparam code_t MN_OUT   = 6'd20;
  localparam code_t MN_OTN   = 6'd21;
  localparam code_t MN_EXF   = 6'd22;
  localparam code_t MN_INA   = 6'd23;
  localparam code_t MN_HLT   = 6'd24;
  localparam code_t MN_SRJ   = 6'd25;
  localparam code_t MN_NOP   = 6'd32;
  localparam code_t MN_BLS   = 6'd33;
  localparam code_t MN_PTA   = 6'd34;
  localparam code_t MN_LS1   = 6'd35;
  localparam code_t MN_LS2   = 6'd36;
  localparam code_t MN_CBC   = 6'd37;
  localparam code_t MN_ATE   = 6'd38;
  localparam code_t MN_ATX   = 6'd39;
  localparam code_t MN_ETA   = 6'd40;
  localparam code_t MN_LS3   = 6'd41;
  localparam code_t MN_LS6   = 6'd42;
  localparam code_t MN_MUT   = 6'd43;
  localparam code_t MN_MUH   = 6'd44;
  localparam code_t MN_RS1   = 6'd45;
  localparam code_t MN_RS2   = 6'd46;
  localparam code_t MN_CIL   = 6'd47;
  localparam code_t MN_CTA   = 6'd48;
  localparam code_t MN_SBU   = 6'd49;
  localparam code_t MN_STP   = 6'd50;
  localparam code_t MN_STE   = 6'd51;
  localparam code_t MN_JPR   = 6'd52;
  localparam code_t MN_UNDEF = 6'd53;
  localparam code_t MN_JPM   = 6'd54;
  localparam code_t MN_IBI   = 6'd55;
  localparam code_t MN_IBO   = 6'd56;
  localparam code_t MN_EXC   = 6'd57;
  localparam code_t MN_OTA   = 6'd58;
  localparam code_t MN_HWI   = 6'd59;
  localparam code_t MN_SLS   = 6'd60;
  localparam code_t MN_SJS   = 6'd61;
  localparam code_t MN_SLJ   = 6'd62;

  typedef struct packed {
    code_t mnemonic_code;
    mode_t address_mode;
    opnd_t short_operand;
    word_t target_address;
    word_t second_address;
    len_t  word_count;
    kind_t step_kind;
    logic  step_extra;
  } out_item_t;

endpackage

>>> design/tbipd_in_if.sv
interface tbipd_in_if;
  import tbipd_pkg::*;

  logic  valid;
  logic  ready;
  word_t instruction_word;
  word_t following_word;
  word_t program_counter;

  modport source (
    output valid, instruction_word, following_word, program_counter,
    input  ready
  );

  modport sink (
    input  valid, instruction_word, following_word, program_counter,
    output ready
  );
endinterface

>>> design/tbipd_out_if.sv
interface tbipd_out_if;
  import tbipd_pkg::*;

  logic  valid;
  logic  ready;
  code_t mnemonic_code;
  mode_t address_mode;
  opnd_t short_operand;
  word_t target_address;
  word_t second_address;
  len_t  word_count;
  kind_t step_kind;
  logic  step_extra;

  modport source (
    output valid, mnemonic_code, address_mode, short_operand, target_address,
           second_address, word_count, step_kind, step_extra,
    input  ready
  );

  modport sink (
    input  valid, mnemonic_code, address_mode, short_operand, target_address,
           second_address, word_count, step_kind, step_extra,
    output ready
  );
endinterface

>>> design/tbipd_oc_add.sv
module tbipd_oc_add (
  input  tbipd_pkg::word_t a_in,
  input  tbipd_pkg::word_t b_in,
  output tbipd_pkg::word_t sum_out
);
  import tbipd_pkg::*;

  logic [WORD_W:0] raw;
  logic [WORD_W:0] folded;
  logic            wrap;

  // end-around fold: a raw sum of all ones or more drops by all ones
  assign raw     = {1'b0, a_in} + {1'b0, b_in};
  assign wrap    = (raw >= {1'b0, WORD_MASK});
  assign folded  = raw - {1'b0, WORD_MASK};
  assign sum_out = wrap ? folded[WORD_W-1:0] : raw[WORD_W-1:0];
endmodule

>>> design/tbipd_decode.sv
module tbipd_decode (
  input  tbipd_pkg::word_t     instr,
  input  tbipd_pkg::word_t     nxt,
  input  tbipd_pkg::word_t     pc,
  input  logic                 ext,
  output tbipd_pkg::out_item_t res
);
  import tbipd_pkg::*;

  logic [5:0] d;
  logic       b6;
  logic       back_sel;
  word_t      disp;
  word_t      rel;
  word_t      plain_sum;

  function automatic code_t alu_code(input logic [3:0] idx, input logic is_ext);
    code_t c;
    c = MN_LP + code_t'(idx);
    if (is_ext && idx == 4'd1) c = MN_SC;
    return c;
  endfunction

  assign d  = instr[5:0];
  assign b6 = instr[6];

  // group 6 jumps take the direction from bit 8, group 7 is always forward, memory references from bit 6
  always_comb begin
    unique case (instr[11:9])
      3'o6:    back_sel = instr[8];
      3'o7:    back_sel = 1'b0;
      default: back_sel = instr[6];
    endcase
  end

  assign disp      = back_sel ? {6'o77, ~d} : {6'o00, d};
  assign plain_sum = pc + {6'o00, d};

  tbipd_oc_add u_add (
    .a_in    (pc),
    .b_in    (disp),
    .sum_out (rel)
  );

  always_comb begin
    res.mnemonic_code  = MN_UNDEF;
    res.address_mode   = AM_NONE;
    res.short_operand  = d;
    res.target_address = '0;
    res.second_address = '0;
    res.word_count     = LEN_ONE;
    res.step_kind      = SK_PLAIN;
    res.step_extra     = 1'b0;

    unique case (instr[11:9])
      3'o0: begin
        if (instr[8:7] != 2'b00) begin
          res.mnemonic_code = alu_code({1'b0, instr[8:6]} - 4'd2, ext);
          res.address_mode  = AM_IMM;
        end else if (!ext) begin
          res.mnemonic_code = b6 ? MN_SHA : MN_ERR;
        end else if (!b6 && instr[5:3] != 3'o0) begin
          res.mnemonic_code = MN_SRJ + code_t'(instr[5:3]) - code_t'(1);
          res.short_operand = {3'o0, instr[2:0]};
        end else if (instr[6:3] == 4'b1100) begin
          res.mnemonic_code = MN_SBU;
          res.short_operand = {3'o0, instr[2:0]};
        end else if (instr[6:3] == 4'b1101) begin
          res.mnemonic_code = MN_STP;
        end else if (instr[6:3] == 4'b1110) begin
          res.mnemonic_code = MN_STE;
        end else begin
          unique case (instr[6:0])
            7'o000: res.mnemonic_code = MN_ERR;
            7'o001: res.mnemonic_code = MN_NOP;
            7'o100, 7'o105, 7'o106: begin
              if (instr[6:0] == 7'o100)      res.mnemonic_code = MN_BLS;
              else if (instr[6:0] == 7'o105) res.mnemonic_code = MN_ATE;
              else                           res.mnemonic_code = MN_ATX;
              res.address_mode   = AM_MEM;
              res.target_address = nxt;
              res.word_count     = LEN_TWO;
              res.step_kind      = SK_COND;
            end
            7'o101: begin
              res.mnemonic_code = MN_PTA;
              if (nxt[11:6] == PTA_MARK) begin
                res.step_kind  = SK_OVER;
                res.step_extra = 1'b1;
              end
            end
            7'o102: res.mnemonic_code = MN_LS1;
            7'o103: res.mnemonic_code = MN_LS2;
            7'o104: res.mnemonic_code = MN_CBC;
            7'o107: res.mnemonic_code = MN_ETA;
            7'o110: res.mnemonic_code = MN_LS3;
            7'o111: res.mnemonic_code = MN_LS6;
            7'o112: res.mnemonic_code = MN_MUT;
            7'o113: res.mnemonic_code = MN_MUH;
            7'o114: res.mnemonic_code = MN_RS1;
            7'o115: res.mnemonic_code = MN_RS2;
            7'o120: res.mnemonic_code = MN_CIL;
            7'o130: res.mnemonic_code = MN_CTA;
            default: res.mnemonic_code = MN_UNDEF;
          endcase
        end
      end

      3'o6: begin
        res.mnemonic_code  = MN_ZJ + code_t'(instr[7:6]);
        res.address_mode   = instr[8] ? AM_BWD : AM_FWD;
        res.target_address = rel;
        res.step_kind      = SK_COND;
      end

      3'o7: begin
        unique case (instr[8:6])
          3'o0: begin
            res.mnemonic_code = MN_JPI;
            res.address_mode  = AM_IND;
            res.step_kind     = SK_OUT;
          end
          3'o1: begin
            if (ext && d[5:1] == 5'd0) begin
              res.mnemonic_code  = d[0] ? MN_JPM : MN_JPR;
              res.address_mode   = AM_MEM;
              res.target_address = nxt;
              res.word_count     = LEN_TWO;
              res.step_kind      = d[0] ? SK_PLAIN : SK_OVER;
            end else begin
              res.mnemonic_code  = MN_JFI;
              res.address_mode   = AM_FWD;
              res.target_address = rel;
            end
          end
          3'o2, 3'o3: begin
            res.word_count = LEN_TWO;
            if (ext && d == 6'o00) begin
              res.mnemonic_code  = b6 ? MN_IBO : MN_IBI;
              res.address_mode   = AM_MEM;
              res.target_address = nxt;
              res.step_kind      = SK_COND;
            end else begin
              res.mnemonic_code  = b6 ? MN_OUT : MN_INP;
              res.address_mode   = AM_FWD;
              res.target_address = rel;
              res.second_address = nxt;
            end
          end
          3'o4: res.mnemonic_code = MN_OTN;
          3'o5: begin
            if (ext && d == 6'o00) begin
              res.mnemonic_code  = MN_EXC;
              res.address_mode   = AM_MEM;
              res.target_address = nxt;
              res.word_count     = LEN_TWO;
            end else begin
              res.mnemonic_code  = MN_EXF;
              res.address_mode   = AM_FWD;
              res.target_address = plain_sum;
            end
          end
          3'o6: begin
            priority if (!ext || d == 6'o00) res.mnemonic_code = MN_INA;
            else if (d == 6'o77)             res.mnemonic_code = MN_OTA;
            else                             res.mnemonic_code = MN_HWI;
          end
          default: begin
            priority if (!ext || d == 6'o00 || d == 6'o77) begin
              res.mnemonic_code = MN_HLT;
            end else if (instr[5:3] == 3'o0) begin
              res.mnemonic_code = MN_SLS;
              res.short_operand = {3'o0, instr[2:0]};
            end else begin
              res.mnemonic_code  = (instr[2:0] != 3'o0) ? MN_SJS : MN_SLJ;
              res.address_mode   = AM_MEM;
              res.second_address = nxt;
              res.word_count     = LEN_TWO;
              res.step_kind      = SK_COND;
            end
          end
        endcase
      end

      default: begin
        // memory reference group, opcode in bits 11..8
        res.mnemonic_code = alu_code(instr[11:8] - 4'd2, ext);
        if (instr[7]) begin
          priority if (!ext || d != 6'o00) begin
            res.address_mode   = b6 ? AM_BWD : AM_FWD;
            res.target_address = rel;
          end else if (b6) begin
            res.address_mode = AM_SPEC;
          end else begin
            res.address_mode   = AM_CONST;
            res.target_address = nxt;
            res.word_count     = LEN_TWO;
          end
        end else if (ext && instr[6:0] == 7'o100) begin
          res.address_mode   = AM_MEM;
          res.target_address = nxt;
          res.word_count     = LEN_TWO;
        end else begin
          res.address_mode = b6 ? AM_IND : AM_DIR;
        end
      end
    endcase
  end
endmodule

>>> design/twelve_bit_instruction_predecoder.sv
// Predecoder for one 12-bit instruction word. Each transaction on in_chan
// carries the instruction, the word after it and its program counter; each
// transaction on out_chan returns the mnemonic code, address mode, 6-bit
// operand, effective or second-word address (ones'-complement relative sum
// for forward and backward forms, a plain sum for EXF), length and step
// flags. The block takes one transaction per clock while out_chan is not
// stalled; an accepted transaction passes through the input register and
// then the result register, with the whole decode as a single short
// combinational pass between them. Both registers advance together
// whenever the result is taken or the result register is empty, so a
// stalled output holds at most two transactions before in_chan.ready
// drops. cfg_wdata[0] selects the base (0) or extended (1, after reset)
// instruction set; write it only while no transaction is in flight.
`include "assert_macros.svh"

module twelve_bit_instruction_predecoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  tbipd_in_if.sink          in_chan,
  tbipd_out_if.source       out_chan
);
  import tbipd_pkg::*;

  logic      ext_model_r;
  logic      ext_model_nxt;

  logic      in_valid_r;
  logic      in_valid_nxt;
  word_t     instr_r;
  word_t     follow_r;
  word_t     pc_r;

  logic      res_valid_r;
  logic      res_valid_nxt;
  out_item_t res_r;
  out_item_t res_comb;

  logic      adv_res;
  logic      adv_in;
  logic      in_take;

  // advance the result register when it is empty or being taken
  assign adv_res = !res_valid_r || out_chan.ready;
  assign adv_in  = !in_valid_r || adv_res;
  assign in_take = adv_in && in_chan.valid;

  assign in_chan.ready = adv_in;

  assign ext_model_nxt = cfg_we ? cfg_wdata : ext_model_r;
  assign in_valid_nxt  = adv_in ? in_chan.valid : in_valid_r;
  assign res_valid_nxt = adv_res ? in_valid_r : res_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_model_r <= 1'b1;
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      ext_model_r <= ext_model_nxt;
      in_valid_r  <= in_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // capture the incoming transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      instr_r  <= in_chan.instruction_word;
      follow_r <= in_chan.following_word;
      pc_r     <= in_chan.program_counter;
    end
  end

  tbipd_decode u_decode (
    .instr (instr_r),
    .nxt   (follow_r),
    .pc    (pc_r),
    .ext   (ext_model_r),
    .res   (res_comb)
  );

  // hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (adv_res && in_valid_r) begin
      res_r <= res_comb;
    end
  end

  assign out_chan.valid          = res_valid_r;
  assign out_chan.mnemonic_code  = res_r.mnemonic_code;
  assign out_chan.address_mode   = res_r.address_mode;
  assign out_chan.short_operand  = res_r.short_operand;
  assign out_chan.target_address = res_r.target_address;
  assign out_chan.second_address = res_r.second_address;
  assign out_chan.word_count     = res_r.word_count;
  assign out_chan.step_kind      = res_r.step_kind;
  assign out_chan.step_extra     = res_r.step_extra;

  `ASSERT_PROP(a_ready_when_drained, clk, rst_n, out_chan.ready |-> in_chan.ready)
  `ASSERT_PROP(a_take_fills_stage, clk, rst_n, (in_chan.valid && in_chan.ready) |=> in_valid_r)
  `ASSERT_PROP(a_len_legal, clk, rst_n,
    out_chan.valid |-> (out_chan.word_count == LEN_ONE || out_chan.word_count == LEN_TWO))
  `ASSERT_PROP(a_extra_only_pta, clk, rst_n,
    (out_chan.valid && out_chan.step_extra) |->
      (out_chan.mnemonic_code == MN_PTA && out_chan.step_kind == SK_OVER))
endmodule
